// File: rtl/hbsd_pkg.sv
package hbsd_pkg;

    localparam int NODE_COUNT = 512;
    localparam int IDX_W      = 9;
    localparam int SYM_W      = 8;
    localparam int CNT_W      = 4;
    localparam int BYTE_BITS  = 8;
    localparam int PADDR_W    = 2;
    localparam int PDATA_W    = 32;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_DECODE = 1'b1;

    typedef struct packed {
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
        logic             leaf;
        logic [SYM_W-1:0] sym;
    } node_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_ERRCHK,
        ST_FLUSH
    } state_t;

endpackage

// File: rtl/hbsd_in_if.sv
interface hbsd_in_if;
    import hbsd_pkg::*;

    logic             valid;
    logic             ready;
    logic             action;
    logic [IDX_W-1:0] node_index;
    logic [IDX_W-1:0] left_child;
    logic [IDX_W-1:0] right_child;
    logic             is_leaf;
    logic [SYM_W-1:0] leaf_symbol;
    logic [7:0]       code_byte;
    logic [CNT_W-1:0] bit_count;
    logic             end_of_stream;

    modport source (
        output valid, action, node_index, left_child, right_child, is_leaf,
               leaf_symbol, code_byte, bit_count, end_of_stream,
        input  ready
    );

    modport sink (
        input  valid, action, node_index, left_child, right_child, is_leaf,
               leaf_symbol, code_byte, bit_count, end_of_stream,
        output ready
    );

endinterface

// File: rtl/hbsd_out_if.sv
interface hbsd_out_if;
    import hbsd_pkg::*;

    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic             partial_code_error;

    modport source (
        output valid, symbol, last, partial_code_error,
        input  ready
    );

    modport sink (
        input  valid, symbol, last, partial_code_error,
        output ready
    );

endinterface

// File: rtl/huffman_bit_serial_decoder_core.sv
// Flow: a decode word takes one dependent node-table read per code bit and a re-read per
//   leaf reached by a move, then the done step, the end-of-stream check and the flush;
//   output stalls lengthen it. Load words go in one per cycle while the block is idle; no
//   new word is taken until a decode word has been flushed.
// Reset: rst_n is asynchronous, active low; it clears root and walk position to node 0
//   and empties the output register. The node table is not cleared.
module huffman_bit_serial_decoder_core (
    input  logic                         clk,
    input  logic                         rst_n,
    hbsd_in_if.sink                      din,
    hbsd_out_if.source                   dout,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hbsd_pkg::PADDR_W-1:0] paddr,
    input  logic [hbsd_pkg::PDATA_W-1:0] pwdata,
    output logic [hbsd_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import hbsd_pkg::*;

    // Node table: one write port (load words), one registered read port (walk).
    node_t node_mem [NODE_COUNT];
    node_t node_rd_reg;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] root_reg, root_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic             pend_reg, pend_next;

    // Code bits shift out MSB first, one for each walk step that uses a bit.
    logic [BYTE_BITS-1:0] code_reg, code_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic                 eos_reg, eos_next;

    // One-deep hold stage: a result waits here until we know whether it is
    // the last one of the word.
    logic             hold_valid_reg, hold_valid_next;
    logic [SYM_W-1:0] hold_sym_reg, hold_sym_next;
    logic             hold_err_reg, hold_err_next;

    logic             out_valid_reg, out_valid_next;
    logic [SYM_W-1:0] out_sym_reg, out_sym_next;
    logic             out_last_reg, out_last_next;
    logic             out_err_reg, out_err_next;

    logic cfg_wr;
    logic in_fire;
    logic load_wr;
    logic dec_start;
    logic has_bits;
    logic walk_emit;
    logic walk_move;
    logic walk_done;
    logic consume;
    logic err_emit;
    logic produce;
    logic out_free;
    logic stall;
    logic flush_push;
    logic push;
    logic [CNT_W-1:0] count_clamped;

    // ---------------- configuration port ----------------
    // Single register; every address decodes to root_index.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = PDATA_W'(root_reg);

    // ---------------- handshake ----------------
    assign din.ready   = (state_reg == ST_IDLE);
    assign in_fire     = din.valid && din.ready;
    assign load_wr     = in_fire && (din.action == ACT_LOAD);
    assign dec_start   = in_fire && (din.action == ACT_DECODE);

    assign dout.valid              = out_valid_reg;
    assign dout.symbol             = out_sym_reg;
    assign dout.last               = out_last_reg;
    assign dout.partial_code_error = out_err_reg;

    assign count_clamped = (din.bit_count > CNT_W'(BYTE_BITS)) ? CNT_W'(BYTE_BITS)
                                                               : din.bit_count;

    // ---------------- walk control ----------------
    // node_rd_reg always holds the entry of cur_reg. pend_reg marks a node just
    // reached by a move: a leaf there emits without using a code bit, while a
    // leaf found at the start of a bit uses that bit.
    assign has_bits  = (rem_reg != '0);
    assign walk_emit = (state_reg == ST_WALK) && node_rd_reg.leaf && (pend_reg || has_bits);
    assign walk_move = (state_reg == ST_WALK) && !node_rd_reg.leaf && has_bits;
    assign walk_done = (state_reg == ST_WALK) && !walk_emit && !walk_move;
    assign consume   = (walk_emit && !pend_reg) || walk_move;

    // End of stream with the walk stopped off the root gives an error word.
    assign err_emit  = (state_reg == ST_ERRCHK) && eos_reg && (cur_reg != root_reg);
    assign produce   = walk_emit || err_emit;

    assign out_free   = !out_valid_reg || dout.ready;
    assign stall      = produce && hold_valid_reg && !out_free;
    assign flush_push = (state_reg == ST_FLUSH) && hold_valid_reg && out_free;
    assign push       = (produce && !stall && hold_valid_reg) || flush_push;

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (dec_start)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (walk_done)
                begin
                    state_next = ST_ERRCHK;
                end
            end
            ST_ERRCHK:
            begin
                if (!stall)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!hold_valid_reg || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- datapath ----------------
    always_comb
    begin
        root_next       = root_reg;
        cur_next        = cur_reg;
        pend_next       = pend_reg;
        code_next       = code_reg;
        rem_next        = rem_reg;
        eos_next        = eos_reg;
        hold_valid_next = hold_valid_reg;
        hold_sym_next   = hold_sym_reg;
        hold_err_next   = hold_err_reg;
        out_valid_next  = out_valid_reg;
        out_sym_next    = out_sym_reg;
        out_last_next   = out_last_reg;
        out_err_next    = out_err_reg;

        // Root write also moves the walk to the new root.
        if (cfg_wr)
        begin
            root_next = pwdata[IDX_W-1:0];
            cur_next  = pwdata[IDX_W-1:0];
        end

        if (dec_start)
        begin
            code_next = din.code_byte;
            rem_next  = count_clamped;
            eos_next  = din.end_of_stream;
            pend_next = 1'b0;
        end

        if (!stall)
        begin
            if (walk_emit)
            begin
                cur_next  = root_reg;
                pend_next = 1'b0;
            end
            else if (walk_move)
            begin
                cur_next  = code_reg[BYTE_BITS-1] ? node_rd_reg.right : node_rd_reg.left;
                pend_next = 1'b1;
            end
            else if (err_emit)
            begin
                cur_next = root_reg;
            end

            if (consume)
            begin
                code_next = {code_reg[BYTE_BITS-2:0], 1'b0};
                rem_next  = rem_reg - CNT_W'(1);
            end
        end

        // Output register drains, then may refill from the hold stage.
        if (dout.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (push)
        begin
            out_valid_next = 1'b1;
            out_sym_next   = hold_sym_reg;
            out_err_next   = hold_err_reg;
            out_last_next  = flush_push;
        end

        if (flush_push)
        begin
            hold_valid_next = 1'b0;
        end
        if (produce && !stall)
        begin
            hold_valid_next = 1'b1;
            hold_sym_next   = err_emit ? '0 : node_rd_reg.sym;
            hold_err_next   = err_emit;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            root_reg       <= '0;
            cur_reg        <= '0;
            pend_reg       <= 1'b0;
            rem_reg        <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            root_reg       <= root_next;
            cur_reg        <= cur_next;
            pend_reg       <= pend_next;
            rem_reg        <= rem_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg     <= code_next;
        eos_reg      <= eos_next;
        hold_sym_reg <= hold_sym_next;
        hold_err_reg <= hold_err_next;
        out_sym_reg  <= out_sym_next;
        out_last_reg <= out_last_next;
        out_err_reg  <= out_err_next;
    end

    // Table read follows the next walk position so the entry is ready when
    // the walk gets there; a write in the same cycle to that entry is picked
    // up by the re-read in the following idle cycle.
    always_ff @(posedge clk)
    begin
        if (load_wr)
        begin
            node_mem[din.node_index] <= node_t'{
                left:  din.left_child,
                right: din.right_child,
                leaf:  din.is_leaf,
                sym:   din.leaf_symbol
            };
        end
        node_rd_reg <= node_mem[cur_next];
    end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import hbsd_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int SETTLE_CYCLES = 32;      // > worst walk, with its pipeline
    localparam int PHASES        = 8;
    localparam int PHASE_WORDS   = 31;
    localparam logic [PADDR_W-1:0] ROOT_ADDR = '0;   // root_index, register 0

    // Input word as the tree walker sees it: load fields and decode fields side by side.
    typedef struct {
        logic             action;
        logic [IDX_W-1:0] node_index;
        logic [IDX_W-1:0] left_child;
        logic [IDX_W-1:0] right_child;
        logic             is_leaf;
        logic [SYM_W-1:0] leaf_symbol;
        logic [7:0]       code_byte;
        logic [CNT_W-1:0] bit_count;
        logic             end_of_stream;
    } stim_t;

    // One decoded symbol (or the partial-code error) on the output channel.
    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             last;
        logic             err;
    } sym_result_t;

    typedef enum logic {
        ROW_WORD,
        ROW_ROOT
    } row_kind_t;

    // Directed stimulus row. Rows with lit set carry their expected output typed in:
    // lit_n is 0 (no word out) or 1 (exactly lit_res). Others go through the predictor.
    typedef struct {
        row_kind_t        kind;
        stim_t            w;
        logic [IDX_W-1:0] root;
        bit               lit;
        int               lit_n;
        sym_result_t      lit_res;
    } plan_row_t;

    logic clk;
    logic rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    hbsd_in_if  din_bus ();
    hbsd_out_if dout_bus ();

    huffman_bit_serial_decoder_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .din     (din_bus),
        .dout    (dout_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // Shadow of the decoder: node table, root register, walk position.
    // ------------------------------------------------------------------
    node_t            tree_mem [NODE_COUNT];
    logic [IDX_W-1:0] root_q;
    logic [IDX_W-1:0] walk_pos;

    // Nodes written so far. Random non-leaf loads only point at these, so every walk
    // stays on written entries (leaf children are never followed).
    bit               node_known [NODE_COUNT];
    logic [IDX_W-1:0] known_list [$];

    sym_result_t due_syms [$];     // decoded words still owed by the DUT
    int          errors;
    int          send_idle_pct;
    int          recv_stall_pct;
    plan_row_t   plan [$];

    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    // Applies one accepted word to the shadow state, returns the words it decodes to.
    task automatic walk_predict(input stim_t w, ref sym_result_t res[$]);
        logic [IDX_W-1:0] pos;
        int               nbits;
        logic             b;
        res.delete();
        if (w.action == ACT_LOAD)
        begin
            tree_mem[w.node_index] = '{left: w.left_child, right: w.right_child,
                                       leaf: w.is_leaf, sym: w.leaf_symbol};
            if (!node_known[w.node_index])
            begin
                node_known[w.node_index] = 1'b1;
                known_list.push_back(w.node_index);
            end
            return;
        end
        // counts above a byte clamp to eight bits
        nbits = (w.bit_count > BYTE_BITS) ? BYTE_BITS : int'(w.bit_count);
        pos = walk_pos;
        for (int i = 0; i < nbits; i++)
        begin
            b = w.code_byte[BYTE_BITS-1-i];
            // walk already parked on a leaf (leaf root, or node rewritten mid-walk):
            // the bit just emits it
            if (tree_mem[pos].leaf)
            begin
                res.push_back('{sym: tree_mem[pos].sym, last: 1'b0, err: 1'b0});
                pos = root_q;
                continue;
            end
            pos = b ? tree_mem[pos].right : tree_mem[pos].left;
            if (tree_mem[pos].leaf)
            begin
                res.push_back('{sym: tree_mem[pos].sym, last: 1'b0, err: 1'b0});
                pos = root_q;
            end
        end
        // stream ends inside a code
        if (w.end_of_stream && pos != root_q)
        begin
            res.push_back('{sym: '0, last: 1'b0, err: 1'b1});
            pos = root_q;
        end
        walk_pos = pos;
        if (res.size() != 0)
            res[res.size()-1].last = 1'b1;
    endtask

    // Drives one word, holding valid until accepted. Valid drops only ahead of an
    // idle cycle, so back-to-back words keep it high with no glitch.
    task automatic send_word(input stim_t w, input bit lit = 1'b0, input int lit_n = 0,
                             input sym_result_t lit_res = '0);
        sym_result_t res [$];
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            din_bus.valid <= 1'b0;
            @(negedge clk);
        end
        din_bus.valid         <= 1'b1;
        din_bus.action        <= w.action;
        din_bus.node_index    <= w.node_index;
        din_bus.left_child    <= w.left_child;
        din_bus.right_child   <= w.right_child;
        din_bus.is_leaf       <= w.is_leaf;
        din_bus.leaf_symbol   <= w.leaf_symbol;
        din_bus.code_byte     <= w.code_byte;
        din_bus.bit_count     <= w.bit_count;
        din_bus.end_of_stream <= w.end_of_stream;
        do @(posedge clk); while (!din_bus.ready);
        walk_predict(w, res);
        if (lit)
        begin
            if (lit_n == 1)
                due_syms.push_back(lit_res);
        end
        else
        begin
            foreach (res[i])
                due_syms.push_back(res[i]);
        end
    endtask

    // Lets the block go quiet: input idle, all owed words out, then a walk's worth
    // of cycles in case the last decode emits nothing.
    task automatic settle();
        @(negedge clk);
        din_bus.valid <= 1'b0;
        while (due_syms.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write of root_index, then read-back. Writing the root also resets the walk.
    task automatic write_root(input logic [IDX_W-1:0] v);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ROOT_ADDR;
        pwdata  <= PDATA_W'(v);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        root_q   = v;
        walk_pos = v;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== PDATA_W'(v))
        begin
            $display("%0t: root_index read expected %h actual %h",
                     $time, PDATA_W'(v), prdata);
            errors++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic plan_row_t load_row(int idx, int l, int r, bit leaf, int sym);
        plan_row_t row;
        row = '{kind: ROW_WORD, w: '{default: '0}, root: '0, lit: 1'b1, lit_n: 0,
                lit_res: '0};
        row.w.action      = ACT_LOAD;
        row.w.node_index  = IDX_W'(idx);
        row.w.left_child  = IDX_W'(l);
        row.w.right_child = IDX_W'(r);
        row.w.is_leaf     = leaf;
        row.w.leaf_symbol = SYM_W'(sym);
        return row;
    endfunction

    function automatic plan_row_t code_row(int code, int cnt, bit eos);
        plan_row_t row;
        row = '{kind: ROW_WORD, w: '{default: '0}, root: '0, lit: 1'b0, lit_n: 0,
                lit_res: '0};
        row.w.action        = ACT_DECODE;
        row.w.code_byte     = 8'(code);
        row.w.bit_count     = CNT_W'(cnt);
        row.w.end_of_stream = eos;
        return row;
    endfunction

    function automatic plan_row_t code_lit(int code, int cnt, bit eos, int n, int sym,
                                           bit err);
        plan_row_t row;
        row         = code_row(code, cnt, eos);
        row.lit     = 1'b1;
        row.lit_n   = n;
        row.lit_res = '{sym: SYM_W'(sym), last: 1'b1, err: err};
        return row;
    endfunction

    function automatic plan_row_t root_row(int v);
        plan_row_t row;
        row = '{kind: ROW_ROOT, w: '{default: '0}, root: IDX_W'(v), lit: 1'b0, lit_n: 0,
                lit_res: '0};
        return row;
    endfunction

    // Random word: mostly decodes. Leaf loads take any children (never followed);
    // non-leaf loads point only at written nodes. Decode-only fields ride along as
    // noise on loads and vice versa.
    function automatic stim_t random_word();
        stim_t w;
        w.action        = ($urandom_range(99) < 30) ? ACT_LOAD : ACT_DECODE;
        w.node_index    = IDX_W'($urandom_range(NODE_COUNT-1));
        w.is_leaf       = 1'($urandom_range(1));
        w.leaf_symbol   = SYM_W'($urandom_range(255));
        w.left_child    = IDX_W'($urandom_range(NODE_COUNT-1));
        w.right_child   = IDX_W'($urandom_range(NODE_COUNT-1));
        w.code_byte     = 8'($urandom_range(255));
        w.end_of_stream = ($urandom_range(3) == 0);
        // mostly legal counts; now and then zero or past a byte
        if ($urandom_range(4) != 0)
            w.bit_count = CNT_W'($urandom_range(BYTE_BITS, 1));
        else
            w.bit_count = CNT_W'($urandom_range(15));
        if (w.action == ACT_LOAD && !w.is_leaf)
        begin
            w.left_child  = known_list[$urandom_range(known_list.size()-1)];
            w.right_child = known_list[$urandom_range(known_list.size()-1)];
        end
        return w;
    endfunction

    // Output side: random backpressure at the current phase's rate.
    always @(negedge clk)
        dout_bus.ready <= ($urandom_range(99) >= recv_stall_pct);

    // Checker: each accepted word against the oldest owed one.
    always @(posedge clk)
    begin
        sym_result_t got;
        sym_result_t want;
        if (rst_n && dout_bus.valid && dout_bus.ready)
        begin
            got = '{sym: dout_bus.symbol, last: dout_bus.last,
                    err: dout_bus.partial_code_error};
            if (due_syms.size() == 0)
            begin
                $display("%0t: unexpected word, expected none actual sym=%h last=%b err=%b",
                         $time, got.sym, got.last, got.err);
                errors++;
            end
            else
            begin
                want = due_syms.pop_front();
                if (got.sym !== want.sym || got.last !== want.last || got.err !== want.err)
                begin
                    $display("%0t: expected sym=%h last=%b err=%b actual sym=%h last=%b err=%b",
                             $time, want.sym, want.last, want.err,
                             got.sym, got.last, got.err);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #(5_000_000);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        logic [IDX_W-1:0] new_root;

        rst_n                 = 1'b0;
        din_bus.valid         = 1'b0;
        din_bus.action        = ACT_LOAD;
        din_bus.node_index    = '0;
        din_bus.left_child    = '0;
        din_bus.right_child   = '0;
        din_bus.is_leaf       = 1'b0;
        din_bus.leaf_symbol   = '0;
        din_bus.code_byte     = '0;
        din_bus.bit_count     = '0;
        din_bus.end_of_stream = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        errors                = 0;
        send_idle_pct         = 0;
        recv_stall_pct        = 0;
        root_q                = '0;
        walk_pos              = '0;
        foreach (tree_mem[i])
        begin
            tree_mem[i]   = '0;
            node_known[i] = 1'b0;
        end

        // Directed tree: 0 -> {1, 511}; 511 -> {2, 3}; leaves 1=00, 2=FF, 3=A5.
        plan.push_back(load_row(0, 1, 511, 1'b0, 8'h00));
        plan.push_back(load_row(1, 511, 0, 1'b1, 8'h00));
        plan.push_back(load_row(511, 2, 3, 1'b0, 8'hFF));
        plan.push_back(load_row(2, 0, 511, 1'b1, 8'hFF));
        plan.push_back(load_row(3, 3, 3, 1'b1, 8'hA5));
        plan.push_back(code_lit(8'h00, 1, 1'b0, 1, 8'h00, 1'b0));  // one-bit code
        plan.push_back(code_lit(8'h80, 1, 1'b0, 0, 0, 1'b0));      // walk parks on 511
        plan.push_back(code_lit(8'h00, 1, 1'b0, 1, 8'hFF, 1'b0));  // code split over words
        plan.push_back(code_lit(8'h80, 1, 1'b1, 1, 0, 1'b1));      // ends inside a code
        plan.push_back(code_row(8'hC0, 3, 1'b0));
        plan.push_back(code_row(8'hFF, 8, 1'b1));
        plan.push_back(code_lit(8'hAA, 0, 1'b1, 0, 0, 1'b0));      // zero bits, at root
        plan.push_back(code_row(8'h00, 15, 1'b0));                 // count clamps, 8 out
        plan.push_back(code_row(8'h55, 9, 1'b0));                  // ends parked on 511
        plan.push_back(code_lit(8'h00, 0, 1'b1, 1, 0, 1'b1));      // zero bits still ends
        plan.push_back(code_lit(8'h80, 1, 1'b0, 0, 0, 1'b0));
        plan.push_back(load_row(511, 0, 0, 1'b1, 8'h3C));          // rewrite under the walk
        plan.push_back(code_lit(8'h00, 1, 1'b0, 1, 8'h3C, 1'b0));
        plan.push_back(root_row(2));                               // root is a leaf
        plan.push_back(code_row(8'h00, 3, 1'b1));
        plan.push_back(load_row(511, 2, 3, 1'b0, 8'h00));
        plan.push_back(root_row(511));
        plan.push_back(code_lit(8'h00, 1, 1'b1, 1, 8'hFF, 1'b0));
        plan.push_back(root_row(0));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_ROOT)
            begin
                settle();
                write_root(plan[i].root);
            end
            else
                send_word(plan[i].w, plan[i].lit, plan[i].lit_n, plan[i].lit_res);
        end

        // Random phases: idling pattern rotates; root moves each phase, to the extremes in phases 1 and 2.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            unique case (phase % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 88;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 88;
                end
                default:
                begin
                    send_idle_pct  = 6;
                    recv_stall_pct = 6;
                end
            endcase
            if (phase == 1)
                new_root = IDX_W'(NODE_COUNT-1);
            else if (phase == 2)
                new_root = '0;
            else
                new_root = known_list[$urandom_range(known_list.size()-1)];
            write_root(new_root);
            repeat (PHASE_WORDS)
                send_word(random_word());
        end

        settle();
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
